// ----- rtl/core/square_channel_with_frequency_sweep_defines.svh -----
// assertion macros for the square channel with frequency sweep
`ifndef SQUARE_CHANNEL_WITH_FREQUENCY_SWEEP_DEFINES_SVH
`define SQUARE_CHANNEL_WITH_FREQUENCY_SWEEP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while in reset
`define SQCH_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sqch assertion failed");
// next-cycle implication, disabled while in reset
`define SQCH_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sqch assertion failed");
`else
`define SQCH_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons)
`define SQCH_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/sqch_pkg.sv -----
// types, event codes and constants of the square channel with frequency sweep
package sqch_pkg;

	localparam logic [2:0] FUNC_SWEEP_WR = 3'd0;
	localparam logic [2:0] FUNC_DUTY_WR  = 3'd1;
	localparam logic [2:0] FUNC_TRIGGER  = 3'd2;
	localparam logic [2:0] FUNC_TICK     = 3'd3;
	localparam logic [2:0] FUNC_SAMPLE   = 3'd4;

	localparam logic [11:0] FREQ_LIMIT = 12'd2048;
	localparam logic [3:0]  PERIOD_ZERO_RELOAD = 4'd8;

	// bit n of a pattern is the output at duty step n
	localparam logic [3:0][7:0] DUTY_PATTERNS = {
		8'b0111_1110,
		8'b1110_0001,
		8'b1000_0001,
		8'b1000_0000
	};

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  reg_value;
		logic [10:0] frequency;
		logic [3:0]  volume;
	} item_t;

	typedef struct packed {
		logic        channel_on;
		logic [10:0] frequency_out;
		logic        frequency_updated;
		logic [3:0]  sample;
	} result_t;

endpackage

// ----- rtl/core/sqch_calc.sv -----
// one sweep calculation: base plus or minus base shifted right
module sqch_calc
	import sqch_pkg::*;
(
	input  logic [10:0] base,
	input  logic [2:0]  shift,
	input  logic        negate,
	output logic [11:0] value
);

	logic [10:0] delta;

	assign delta = base >> shift;

	// delta never exceeds base, so the difference stays non-negative
	assign value = negate ? ({1'b0, base} - {1'b0, delta})
	                      : ({1'b0, base} + {1'b0, delta});

endmodule

// ----- rtl/core/sqch_in_reg.sv -----
// input register holding one event beat ahead of the channel logic
module sqch_in_reg
	import sqch_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  pop,
	output logic  valid_s1,
	output item_t item_s1
);

	logic valid_q;

	assign item_ready = !valid_q || pop;
	assign valid_s1   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ----- rtl/core/sqch_channel.sv -----
// sweep, trigger and duty state with the result register
module sqch_channel
	import sqch_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  item_t   item_s1,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic [2:0]  period_q;
	logic        negate_q;
	logic [2:0]  shift_q;
	logic [3:0]  countdown_q;
	logic [10:0] shadow_q;
	logic [10:0] freq_q;
	logic        active_q;
	logic        calc_done_q;
	logic        enabled_q;
	logic [1:0]  duty_sel_q;
	logic [2:0]  duty_step_q;
	logic        result_valid_q;

	logic [2:0]  period_d;
	logic        negate_d;
	logic [2:0]  shift_d;
	logic [3:0]  countdown_d;
	logic [10:0] shadow_d;
	logic [10:0] freq_d;
	logic        active_d;
	logic        calc_done_d;
	logic        enabled_d;
	logic [1:0]  duty_sel_d;
	logic [2:0]  duty_step_d;
	logic        updated_d;
	logic [3:0]  sample_d;

	logic [10:0] calc_base;
	logic [11:0] calc_first;
	logic [11:0] calc_second;
	logic [3:0]  reload;
	logic [3:0]  count_dec;
	logic [7:0]  pattern;

	// trigger calculates from the incoming frequency, a tick from the shadow
	assign calc_base = (item_s1.func == FUNC_TRIGGER) ? item_s1.frequency : shadow_q;

	sqch_calc u_calc_first (
		.base   (calc_base),
		.shift  (shift_q),
		.negate (negate_q),
		.value  (calc_first)
	);

	// second pass runs on the freshly written shadow value
	sqch_calc u_calc_second (
		.base   (calc_first[10:0]),
		.shift  (shift_q),
		.negate (negate_q),
		.value  (calc_second)
	);

	assign reload    = (period_q == 3'd0) ? PERIOD_ZERO_RELOAD : {1'b0, period_q};
	assign count_dec = (countdown_q != 4'd0) ? (countdown_q - 4'd1) : 4'd0;
	assign pattern   = DUTY_PATTERNS[duty_sel_q];

	always_comb begin
		period_d    = period_q;
		negate_d    = negate_q;
		shift_d     = shift_q;
		countdown_d = countdown_q;
		shadow_d    = shadow_q;
		freq_d      = freq_q;
		active_d    = active_q;
		calc_done_d = calc_done_q;
		enabled_d   = enabled_q;
		duty_sel_d  = duty_sel_q;
		duty_step_d = duty_step_q;
		updated_d   = 1'b0;
		sample_d    = 4'd0;
		unique case (item_s1.func)
			FUNC_SWEEP_WR: begin
				period_d = item_s1.reg_value[6:4];
				negate_d = item_s1.reg_value[3];
				shift_d  = item_s1.reg_value[2:0];
				// leaving negate mode after a calculation kills the channel
				if (negate_q && !item_s1.reg_value[3] && calc_done_q) begin
					enabled_d = 1'b0;
				end
				calc_done_d = 1'b0;
			end
			FUNC_DUTY_WR: begin
				duty_sel_d = item_s1.reg_value[7:6];
			end
			FUNC_TRIGGER: begin
				enabled_d   = 1'b1;
				shadow_d    = item_s1.frequency;
				freq_d      = item_s1.frequency;
				countdown_d = reload;
				active_d    = (shift_q != 3'd0) || (period_q != 3'd0);
				if (shift_q != 3'd0) begin
					calc_done_d = 1'b1;
					if (calc_first >= FREQ_LIMIT) begin
						enabled_d = 1'b0;
					end
				end
			end
			FUNC_TICK: begin
				if (count_dec != 4'd0) begin
					countdown_d = count_dec;
				end else begin
					countdown_d = reload;
					if (active_q && period_q != 3'd0) begin
						calc_done_d = 1'b1;
						if (calc_first >= FREQ_LIMIT) begin
							enabled_d = 1'b0;
						end else if (shift_q != 3'd0) begin
							shadow_d  = calc_first[10:0];
							freq_d    = calc_first[10:0];
							updated_d = 1'b1;
							if (calc_second >= FREQ_LIMIT) begin
								enabled_d = 1'b0;
							end
						end
					end
				end
			end
			FUNC_SAMPLE: begin
				sample_d    = pattern[duty_step_q] ? item_s1.volume : 4'd0;
				duty_step_d = duty_step_q + 3'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q       <= '0;
			negate_q       <= 1'b0;
			shift_q        <= '0;
			countdown_q    <= '0;
			shadow_q       <= '0;
			freq_q         <= '0;
			active_q       <= 1'b0;
			calc_done_q    <= 1'b0;
			enabled_q      <= 1'b0;
			duty_sel_q     <= '0;
			duty_step_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				period_q    <= period_d;
				negate_q    <= negate_d;
				shift_q     <= shift_d;
				countdown_q <= countdown_d;
				shadow_q    <= shadow_d;
				freq_q      <= freq_d;
				active_q    <= active_d;
				calc_done_q <= calc_done_d;
				enabled_q   <= enabled_d;
				duty_sel_q  <= duty_sel_d;
				duty_step_q <= duty_step_d;
			end
			if (take) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result.channel_on        <= enabled_d;
			result.frequency_out     <= freq_d;
			result.frequency_updated <= updated_d;
			result.sample            <= sample_d;
		end
	end

	assign result_valid = result_valid_q;

endmodule

// ----- rtl/core/square_channel_with_frequency_sweep.sv -----
// square channel with frequency sweep: input register, channel logic, result register
//
// Each item beat on the item channel is one event: a sweep register write, a duty
// register write, a trigger, a sweep tick or a sample step. Every event returns
// exactly one result beat carrying the channel-on flag, the current frequency, a
// flag for a sweep write-back and the scaled duty sample.
// The item beat waits in the input register until the result register is free or
// draining; its result is then registered there and held until result_ready is high.
// Throughput: one item per cycle unless results stall; the whole event is handled
// by a shift and two chained 12-bit add/subtract-and-compare units between the input
// register and the result register, so back-to-back items flow without a bubble.
// A stalled result is held in the result register while the input register keeps
// taking one more item; item_ready drops once both are full and comes back in the
// cycle result_ready is seen high.
// Reset clears all sweep, duty and channel state to zero and empties both
// registers; the block is ready for items in the first cycle after reset.
`include "square_channel_with_frequency_sweep_defines.svh"

module square_channel_with_frequency_sweep
	import sqch_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic  stage_valid;
	item_t item_s1;
	logic  advance;

	// the staged event moves on when the result register is free or drains now
	assign advance = stage_valid && (!result_valid || result_ready);

	sqch_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.pop        (advance),
		.valid_s1   (stage_valid),
		.item_s1    (item_s1)
	);

	sqch_channel u_channel (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (advance),
		.item_s1      (item_s1),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`SQCH_ASSERT_IMPL(a_empty_stage_ready, clk, arst_n, !stage_valid, item_ready)
	`SQCH_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, result_valid)
	`SQCH_ASSERT_IMPL(a_update_has_no_sample, clk, arst_n,
		result_valid && result.frequency_updated, result.sample == 4'd0)

endmodule

// ----- dv/square_channel_with_frequency_sweep_test.sv -----
// testbench for the square channel with frequency sweep: directed and random events
`timescale 1ns / 1ps

module square_channel_with_frequency_sweep_test;
	import sqch_pkg::*;

	localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_MID   = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item_beat = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result_beat;

	square_channel_with_frequency_sweep dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_beat)
	);

	always #5 clk = ~clk;

	// channel model state
	logic [2:0]  sw_period = '0;
	logic        sw_negate = 1'b0;
	logic [2:0]  sw_shift = '0;
	logic [3:0]  sw_timer = '0;
	logic [10:0] shadow_f = '0;
	logic [10:0] cur_f = '0;
	logic        sw_enabled = 1'b0;
	logic        calc_seen = 1'b0;
	logic        chan_on = 1'b0;
	logic [1:0]  wave_sel = '0;
	logic [2:0]  wave_pos = '0;

	result_t pending_results[$];
	int      sender_idle_pct = 0;
	int      receiver_stall_pct = 0;
	int      mismatch_count = 0;
	int      results_checked = 0;
	int      writebacks_seen = 0;
	int      disables_seen = 0;
	int      func_hits[8];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch after %0d results: %s got 0x%0h expected 0x%0h at %0t",
			results_checked, what, got, want, $time);
		mismatch_count++;
	endtask

	function automatic logic wave_bit(input logic [1:0] sel, input logic [2:0] pos);
		case (sel)
			2'd0:    return pos == 3'd7;
			2'd1:    return pos == 3'd0 || pos == 3'd7;
			2'd2:    return pos == 3'd0 || pos >= 3'd5;
			default: return pos != 3'd0 && pos != 3'd7;
		endcase
	endfunction

	function automatic logic [11:0] sweep_next();
		logic [11:0] delta;
		delta = {1'b0, shadow_f} >> sw_shift;
		calc_seen = 1'b1;
		return sw_negate ? {1'b0, shadow_f} - delta : {1'b0, shadow_f} + delta;
	endfunction

	function automatic result_t predict_event(input item_t ev);
		result_t     r;
		logic [11:0] nf;
		logic        was_on;
		logic        prev_neg;
		r = '0;
		was_on = chan_on;
		case (ev.func)
			FUNC_SWEEP_WR: begin
				prev_neg = sw_negate;
				sw_period = ev.reg_value[6:4];
				sw_negate = ev.reg_value[3];
				sw_shift = ev.reg_value[2:0];
				// leaving negate mode after a calculation kills the channel
				if (prev_neg && !sw_negate && calc_seen)
					chan_on = 1'b0;
				calc_seen = 1'b0;
			end
			FUNC_DUTY_WR: wave_sel = ev.reg_value[7:6];
			FUNC_TRIGGER: begin
				chan_on = 1'b1;
				shadow_f = ev.frequency;
				cur_f = ev.frequency;
				sw_timer = (sw_period == 3'd0) ? PERIOD_ZERO_RELOAD : {1'b0, sw_period};
				sw_enabled = (sw_shift != 3'd0) || (sw_period != 3'd0);
				if (sw_shift != 3'd0) begin
					if (sweep_next() >= FREQ_LIMIT)
						chan_on = 1'b0;
				end
			end
			FUNC_TICK: begin
				if (sw_timer != 4'd0)
					sw_timer = sw_timer - 4'd1;
				if (sw_timer == 4'd0) begin
					sw_timer = (sw_period == 3'd0) ? PERIOD_ZERO_RELOAD : {1'b0, sw_period};
					if (sw_enabled && sw_period != 3'd0) begin
						nf = sweep_next();
						if (nf >= FREQ_LIMIT) begin
							chan_on = 1'b0;
						end else if (sw_shift != 3'd0) begin
							shadow_f = nf[10:0];
							cur_f = nf[10:0];
							r.frequency_updated = 1'b1;
							writebacks_seen++;
							// overflow look-ahead on the new shadow value
							if (sweep_next() >= FREQ_LIMIT)
								chan_on = 1'b0;
						end
					end
				end
			end
			FUNC_SAMPLE: begin
				r.sample = wave_bit(wave_sel, wave_pos) ? ev.volume : 4'd0;
				wave_pos = wave_pos + 3'd1;
			end
			default: ;
		endcase
		r.channel_on = chan_on;
		r.frequency_out = cur_f;
		if (was_on && !chan_on)
			disables_seen++;
		return r;
	endfunction

	// starts and ends at a falling edge; valid stays up between back-to-back beats
	task automatic send_event(input logic [2:0] f, input logic [7:0] v,
			input logic [10:0] fr, input logic [3:0] vol);
		item_t ev;
		ev.func = f;
		ev.reg_value = v;
		ev.frequency = fr;
		ev.volume = vol;
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item_beat <= ev;
		do
			@(posedge clk);
		while (!item_ready);
		pending_results.push_back(predict_event(ev));
		func_hits[f]++;
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", 32'(result_beat),
					32'd0);
			end else begin
				want = pending_results.pop_front();
				if (result_beat.channel_on !== want.channel_on)
					report_mismatch("channel_on", 32'(result_beat.channel_on),
						32'(want.channel_on));
				if (result_beat.frequency_out !== want.frequency_out)
					report_mismatch("frequency_out", 32'(result_beat.frequency_out),
						32'(want.frequency_out));
				if (result_beat.frequency_updated !== want.frequency_updated)
					report_mismatch("frequency_updated",
						32'(result_beat.frequency_updated),
						32'(want.frequency_updated));
				if (result_beat.sample !== want.sample)
					report_mismatch("sample", 32'(result_beat.sample), 32'(want.sample));
				results_checked++;
			end
		end
	end

	task automatic test_directed_events();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_event(FUNC_SAMPLE, 8'h00, 11'h000, 4'hf);
		send_event(FUNC_DUTY_WR, 8'hff, 11'h7ff, 4'h0);
		send_event(FUNC_SAMPLE, 8'hff, 11'h7ff, 4'hf);
		send_event(FUNC_UNUSED_FIRST, 8'haa, 11'h555, 4'ha);
		send_event(FUNC_UNUSED_MID, 8'h55, 11'h2aa, 4'h5);
		send_event(FUNC_UNUSED_LAST, 8'hff, 11'h7ff, 4'hf);
		// trigger at top frequency with an add sweep overflows at once
		send_event(FUNC_SWEEP_WR, 8'h11, 11'h000, 4'h0);
		send_event(FUNC_TRIGGER, 8'h00, 11'h7ff, 4'h0);
		// period and shift zero: sweep inactive, timer runs from eight
		send_event(FUNC_SWEEP_WR, 8'h00, 11'h000, 4'h0);
		send_event(FUNC_TRIGGER, 8'h00, 11'h000, 4'h0);
		send_event(FUNC_TICK, 8'h00, 11'h000, 4'h0);
		// subtracting sweep with write-back, then negate cleared after calc
		send_event(FUNC_SWEEP_WR, 8'h19, 11'h000, 4'h0);
		send_event(FUNC_TRIGGER, 8'h00, 11'h400, 4'h0);
		send_event(FUNC_TICK, 8'h00, 11'h000, 4'h0);
		send_event(FUNC_SWEEP_WR, 8'h11, 11'h000, 4'h0);
		// longest period, largest shift, subtracting
		send_event(FUNC_SWEEP_WR, 8'h7f, 11'h000, 4'h0);
		send_event(FUNC_TRIGGER, 8'h00, 11'h7ff, 4'h0);
		repeat (7) send_event(FUNC_TICK, 8'hff, 11'h7ff, 4'hf);
		send_event(FUNC_DUTY_WR, 8'h7f, 11'h000, 4'h0);
		send_event(FUNC_SAMPLE, 8'h00, 11'h000, 4'h0);
		send_event(FUNC_SAMPLE, 8'h00, 11'h000, 4'h8);
		wait_results_drained();
	endtask

	task automatic test_random_events(input int n_events, input int s_idle,
			input int r_stall);
		int          sent;
		int          burst;
		int          pick;
		logic [2:0]  f;
		logic [10:0] fr;
		sender_idle_pct = s_idle;
		receiver_stall_pct = r_stall;
		sent = 0;
		while (sent < n_events) begin
			if ($urandom_range(99) < 25) begin
				// sweep setup, trigger, then a run of ticks and samples
				send_event(FUNC_SWEEP_WR, 8'($urandom), 11'($urandom), 4'($urandom));
				fr = ($urandom_range(3) == 0) ? 11'($urandom_range(2047, 1400))
					: 11'($urandom);
				send_event(FUNC_TRIGGER, 8'($urandom), fr, 4'($urandom));
				burst = $urandom_range(30, 6);
				repeat (burst)
					send_event(($urandom_range(3) == 0) ? FUNC_SAMPLE : FUNC_TICK,
						8'($urandom), 11'($urandom), 4'($urandom));
				sent += burst + 2;
			end else begin
				pick = $urandom_range(99);
				if (pick < 10)
					f = FUNC_SWEEP_WR;
				else if (pick < 20)
					f = FUNC_DUTY_WR;
				else if (pick < 32)
					f = FUNC_TRIGGER;
				else if (pick < 62)
					f = FUNC_TICK;
				else if (pick < 94)
					f = FUNC_SAMPLE;
				else
					f = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
				send_event(f, 8'($urandom), 11'($urandom), 4'($urandom));
				sent++;
			end
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_events();
		test_random_events(460, 0, 0);
		test_random_events(460, 52, 0);
		test_random_events(460, 0, 52);
		test_random_events(460, 18, 18);
		$display("covered %0d sweep writes, %0d duty writes, %0d triggers, %0d ticks,",
			func_hits[FUNC_SWEEP_WR], func_hits[FUNC_DUTY_WR], func_hits[FUNC_TRIGGER],
			func_hits[FUNC_TICK]);
		$display("%0d samples, %0d spare codes; %0d results, %0d write-backs, %0d disables",
			func_hits[FUNC_SAMPLE],
			func_hits[FUNC_UNUSED_FIRST] + func_hits[FUNC_UNUSED_MID]
				+ func_hits[FUNC_UNUSED_LAST],
			results_checked, writebacks_seen, disables_seen);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
